[design/srfp_pkg.sv]
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants of the sensor record field parser
// Beat types for both channels, result kinds, record IDs and the length table.
// ----------------------------------------------------------------------------
package srfp_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [1:0] KIND_FIELD     = 2'd0;
	localparam logic [1:0] KIND_UNKNOWN   = 2'd1;
	localparam logic [1:0] KIND_END       = 2'd2;
	localparam logic [1:0] KIND_END_TRUNC = 2'd3;

	localparam logic [7:0] ID_STATUS = 8'd79;
	localparam logic [7:0] ID_FLAG_A = 8'd8;
	localparam logic [7:0] ID_FLAG_B = 8'd9;
	localparam logic [7:0] ID_QUAT   = 8'd77;

	localparam logic [4:0] LEN_NONE = 5'd0;
	localparam logic [4:0] LEN_BYTE = 5'd1;
	localparam logic [4:0] LEN_WORD = 5'd4;
	localparam logic [4:0] LEN_QUAT = 5'd16;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_packet;
	} srfp_in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  field_id;
		logic [1:0]  element_index;
		logic [31:0] field_value;
		logic        last_result;
	} srfp_out_t;

	// Results produced by one byte: up to two, in order.
	typedef struct packed {
		logic [1:0] cnt;
		srfp_out_t  r0;
		srfp_out_t  r1;
	} srfp_pair_t;

	function automatic logic [4:0] payload_length(input logic [7:0] id);
		logic [4:0] len;
		unique case (id)
			8'd5, 8'd24, 8'd25, 8'd7, 8'd21, 8'd22, 8'd23,
			8'd27, 8'd28, 8'd29, 8'd74, 8'd75, 8'd76: len = LEN_WORD;
			ID_QUAT:                                   len = LEN_QUAT;
			ID_STATUS, ID_FLAG_A, ID_FLAG_B:           len = LEN_BYTE;
			default:                                   len = LEN_NONE;
		endcase
		return len;
	endfunction

endpackage

[design/sensor_record_field_parser.sv]
// ----------------------------------------------------------------------------
// sensor_record_field_parser: attitude sensor packet field parser
// Splits a byte stream into ID/payload records and emits one beat per field,
// per unknown ID and per packet end.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   byte     | byte_valid, byte_stall, byte_data        | in
//   result   | result_valid, result_stall, result_data  | out
//   config   | cfg_we, cfg_wdata (big_endian)           | in
//
// A byte is registered on acceptance and decoded once the result queue has
// room; its results are registered in the queue. One byte per cycle
// is taken while the four-entry result queue has room for two results; a
// byte can produce two results, so the output side sets the sustained rate.
// Reset returns the parser to expecting an ID and sets big_endian to 1.
// ----------------------------------------------------------------------------
module sensor_record_field_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  srfp_pkg::srfp_in_t  byte_data,
	output logic                result_valid,
	input  logic                result_stall,
	output srfp_pkg::srfp_out_t result_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import srfp_pkg::*;

	logic       big_endian_q;
	logic       valid_s1;
	srfp_in_t   data_s1;
	logic       room;
	logic       go;
	logic       accept;
	srfp_pair_t res;

	assign go = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				big_endian_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= byte_data;
		end
	end

	srfp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.beat       (data_s1),
		.big_endian (big_endian_q),
		.res        (res)
	);

	srfp_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (go),
		.res          (res),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

[design/srfp_parse.sv]
// ----------------------------------------------------------------------------
// srfp_parse: record parser state and per-byte decode
// Consumes one registered byte when go is high and reports up to two results.
// ----------------------------------------------------------------------------
module srfp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  srfp_pkg::srfp_in_t  beat,
	input  logic                big_endian,
	output srfp_pkg::srfp_pair_t res
);
	import srfp_pkg::*;

	logic        expecting_id_q, expecting_id_n;
	logic [7:0]  current_id_q, current_id_n;
	logic [4:0]  left_q, left_n;
	logic [31:0] word_q, word_n;
	logic [1:0]  biw_q, biw_n;
	logic [1:0]  quat_q, quat_n;

	always_comb begin
		logic [4:0] len;
		logic [7:0] b;
		srfp_out_t  r;
		srfp_out_t  e;
		b = beat.in_byte;
		len = payload_length(b);
		expecting_id_n = expecting_id_q;
		current_id_n = current_id_q;
		left_n = left_q;
		word_n = word_q;
		biw_n = biw_q;
		quat_n = quat_q;
		r = '0;
		res = '0;

		if (expecting_id_q) begin
			if (len == LEN_NONE) begin
				r.result_kind = KIND_UNKNOWN;
				r.field_id = b;
				res.cnt = 2'd1;
			end else begin
				current_id_n = b;
				left_n = len;
				expecting_id_n = 1'b0;
				word_n = '0;
				biw_n = '0;
				quat_n = '0;
			end
		end else if (current_id_q == ID_STATUS || current_id_q == ID_FLAG_A ||
				current_id_q == ID_FLAG_B) begin
			r.result_kind = KIND_FIELD;
			r.field_id = current_id_q;
			r.field_value = (current_id_q == ID_STATUS) ? {24'd0, b} :
				{31'd0, (b != 8'd0)};
			res.cnt = 2'd1;
			left_n = '0;
			expecting_id_n = 1'b1;
		end else begin
			if (biw_q == 2'd0) begin
				word_n = {24'd0, b};
			end else if (big_endian) begin
				word_n = {word_q[23:0], b};
			end else begin
				case (biw_q)
					2'd1:    word_n = word_q | {16'd0, b, 8'd0};
					2'd2:    word_n = word_q | {8'd0, b, 16'd0};
					default: word_n = word_q | {b, 24'd0};
				endcase
			end
			left_n = left_q - 5'd1;
			if (biw_q == 2'd3) begin
				r.result_kind = KIND_FIELD;
				r.field_id = current_id_q;
				r.element_index = (current_id_q == ID_QUAT) ? quat_q : 2'd0;
				r.field_value = word_n;
				res.cnt = 2'd1;
				biw_n = '0;
				quat_n = quat_q + 2'd1;
			end else begin
				biw_n = biw_q + 2'd1;
			end
			if (left_n == 5'd0) begin
				expecting_id_n = 1'b1;
			end
		end

		// The packet end is reported after whatever the byte itself produced.
		e = '0;
		e.result_kind = expecting_id_n ? KIND_END : KIND_END_TRUNC;
		e.last_result = 1'b1;
		if (beat.end_of_packet) begin
			expecting_id_n = 1'b1;
			current_id_n = '0;
			left_n = '0;
			word_n = '0;
			biw_n = '0;
			quat_n = '0;
			if (res.cnt == 2'd0) begin
				res.r0 = e;
				res.cnt = 2'd1;
			end else begin
				res.r0 = r;
				res.r1 = e;
				res.cnt = 2'd2;
			end
		end else begin
			r.last_result = 1'b1;
			res.r0 = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expecting_id_q <= 1'b1;
			current_id_q <= '0;
			left_q <= '0;
			word_q <= '0;
			biw_q <= '0;
			quat_q <= '0;
		end else if (go) begin
			expecting_id_q <= expecting_id_n;
			current_id_q <= current_id_n;
			left_q <= left_n;
			word_q <= word_n;
			biw_q <= biw_n;
			quat_q <= quat_n;
		end
	end

endmodule

[design/srfp_queue.sv]
// ----------------------------------------------------------------------------
// srfp_queue: result queue
// Takes up to two results a cycle and hands out one beat at a time.
// ----------------------------------------------------------------------------
module srfp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  srfp_pkg::srfp_pair_t res,
	output logic                 room,
	output logic                 result_valid,
	input  logic                 result_stall,
	output srfp_pkg::srfp_out_t  result_data
);
	import srfp_pkg::*;

	srfp_out_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic [1:0]         n_push;
	logic               pop;

	assign n_push = push ? res.cnt : 2'd0;
	assign pop = result_valid && !result_stall;
	assign result_valid = (count_q != '0);
	assign result_data = mem_q[rd_ptr_q];
	// Room for a full pair without crediting a read in the same cycle.
	assign room = (count_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= res.r0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

endmodule
